FILE: hw/rtl/vgts_pkg.sv
// Shared types, constants and helpers for the voxel grid trilinear sampler.
`timescale 1ns / 1ps
package vgts_pkg;

  localparam int unsigned GRID_X_DEF = 32;
  localparam int unsigned GRID_Y_DEF = 32;
  localparam int unsigned GRID_Z_DEF = 32;
  localparam int unsigned COORD_W    = 9;      // holds 0..256
  localparam int unsigned FLAT_W     = 24;     // flat index up to 256^3-1
  localparam int unsigned LOAD_W     = 15;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned NBANK      = 8;
  localparam int unsigned MEM_MAX    = 32768;  // reachable by a 15-bit load index
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned QDEPTH     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_SCALE_X  = 3'd3,
    REG_SCALE_Y  = 3'd4,
    REG_SCALE_Z  = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // One classified beat handed from front to back.
  typedef struct packed {
    logic                         is_query;
    logic                         in_box;
    logic                         wr_en;
    logic [LOAD_W-1:0]            wr_addr;
    logic [DATA_W-1:0]            wr_data;
    logic [NBANK-1:0][FLAT_W-1:0] rd_addr;
    logic [FRAC_W-1:0]            tx;
    logic [FRAC_W-1:0]            ty;
    logic [FRAC_W-1:0]            tz;
  } qent_t;

  // floor((a*(65536-t) + b*t) / 65536), truncated to 32 bits
  function automatic logic [DATA_W-1:0] lerp16(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                               logic [FRAC_W-1:0] t);
    logic [FRAC_W:0]   wa;
    logic [48:0]       pa;
    logic [48:0]       pb;
    logic [49:0]       sum;
    wa  = 17'h10000 - {1'b0, t};
    pa  = 49'(a) * 49'(wa);
    pb  = 49'(b) * 49'(t);
    sum = {1'b0, pa} + {1'b0, pb};
    return sum[47:16];
  endfunction

endpackage

FILE: hw/rtl/vgts_front.sv
// Front end: config registers, axis mapping and beat classification.
`timescale 1ns / 1ps
module vgts_front #(
  parameter int unsigned GRID_X = vgts_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = vgts_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z = vgts_pkg::GRID_Z_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vgts_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [vgts_pkg::LOAD_W-1:0]       load_index_i,
  input  logic [31:0]                       load_value_i,
  input  logic signed [31:0]                point_x_i,
  input  logic signed [31:0]                point_y_i,
  input  logic signed [31:0]                point_z_i,
  output logic                              push_o,
  output vgts_pkg::qent_t                   push_data_o,
  input  logic                              full_i
);

  localparam int unsigned CW    = vgts_pkg::COORD_W;
  localparam int unsigned FW    = vgts_pkg::FLAT_W;
  localparam int unsigned CELLS = GRID_X * GRID_Y * GRID_Z;

  logic [2:0][31:0] org_q;
  logic [2:0][31:0] scale_q;
  logic [2:0][31:0] pt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q   <= '0;
      scale_q <= {3{32'd2097152}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vgts_pkg::REG_ORIGIN_X: org_q[0]   <= cfg_data_i;
        vgts_pkg::REG_ORIGIN_Y: org_q[1]   <= cfg_data_i;
        vgts_pkg::REG_ORIGIN_Z: org_q[2]   <= cfg_data_i;
        vgts_pkg::REG_SCALE_X:  scale_q[0] <= cfg_data_i;
        vgts_pkg::REG_SCALE_Y:  scale_q[1] <= cfg_data_i;
        vgts_pkg::REG_SCALE_Z:  scale_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  // Whole front moves together; it holds only when the last stage can't push.
  logic adv;
  logic [2:0] v_q;
  assign adv        = !(v_q[2] && full_i);
  assign in_stall_o = !adv;
  assign push_o     = v_q[2] && !full_i;

  // beat metadata carried alongside
  logic [2:0]                        op_q;
  logic [2:0][vgts_pkg::LOAD_W-1:0]  idx_q;
  logic [2:0][31:0]                  val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q  <= {op_q[1:0], operation_i};
      idx_q <= {idx_q[1:0], load_index_i};
      val_q <= {val_q[1:0], load_value_i};
    end
  end

  logic [2:0][32:0]   off_q;
  logic [2:0]         neg_q;
  logic [2:0][63:0]   s_q;
  logic [2:0]         outside_q;
  logic [2:0][CW-1:0] lo_q;
  logic [2:0][CW-1:0] hi_q;
  logic [2:0][15:0]   t_q;

  function automatic logic [CW-1:0] clampc(logic signed [9:0] i, int unsigned n);
    logic signed [9:0] top;
    top = $signed(10'(n - 1));
    if (i < 0) return '0;
    if (i > top) return CW'(n - 1);
    return CW'(i);
  endfunction

  for (genvar a = 0; a < 3; a++) begin : g_axis
    localparam int unsigned NA = (a == 0) ? GRID_X : (a == 1) ? GRID_Y : GRID_Z;
    logic [25:0]       vv;
    logic signed [9:0] ii;
    logic signed [9:0] ip;

    assign vv = {1'b0, s_q[a][40:16]} - 26'h8000;
    assign ii = $signed(vv[25:16]);
    assign ip = ii + 10'sd1;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        off_q[a]     <= {pt[a][31], pt[a]} - {org_q[a][31], org_q[a]};
        neg_q[a]     <= off_q[a][32];
        s_q[a]       <= 64'(off_q[a][31:0]) * 64'(scale_q[a]);
        outside_q[a] <= neg_q[a] || (s_q[a] > (64'(NA) << 32));
        lo_q[a]      <= clampc(ii, NA);
        hi_q[a]      <= clampc(ip, NA);
        t_q[a]       <= vv[15:0];
      end
    end
  end

  // neighbor flat addresses, bank k = {dz, dy, dx}
  always_comb begin
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] cz;
    push_data_o.is_query = (op_q[2] == vgts_pkg::OP_QUERY);
    push_data_o.in_box   = !(|outside_q);
    push_data_o.wr_en    = (32'(idx_q[2]) < 32'(CELLS));
    push_data_o.wr_addr  = idx_q[2];
    push_data_o.wr_data  = val_q[2];
    push_data_o.tx       = t_q[0];
    push_data_o.ty       = t_q[1];
    push_data_o.tz       = t_q[2];
    for (int k = 0; k < vgts_pkg::NBANK; k++) begin
      cx = k[0] ? hi_q[0] : lo_q[0];
      cy = k[1] ? hi_q[1] : lo_q[1];
      cz = k[2] ? hi_q[2] : lo_q[2];
      push_data_o.rd_addr[k] = FW'((FW'(cz) * FW'(GRID_Y) + FW'(cy)) * FW'(GRID_X) + FW'(cx));
    end
  end

endmodule

FILE: hw/rtl/vgts_queue.sv
// Short FIFO between front and back.
`timescale 1ns / 1ps
module vgts_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vgts_pkg::qent_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output vgts_pkg::qent_t pop_data_o
);

  localparam int unsigned D  = vgts_pkg::QDEPTH;
  localparam int unsigned PW = $clog2(D);

  vgts_pkg::qent_t   mem_q [D];
  logic [PW-1:0]     wp_q;
  logic [PW-1:0]     rp_q;
  logic [PW:0]       cnt_q;

  assign full_o     = (cnt_q == (PW+1)'(D));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

endmodule

FILE: hw/rtl/vgts_back.sv
// Back end: replicated grid memory, trilinear blend pipeline, result register.
`timescale 1ns / 1ps
module vgts_back #(
  parameter int unsigned GRID_X = vgts_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = vgts_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z = vgts_pkg::GRID_Z_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  vgts_pkg::qent_t pop_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [31:0]     density_o,
  output logic            inside_res_o
);

  localparam int unsigned CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned DEPTH = (CELLS < vgts_pkg::MEM_MAX) ? CELLS : vgts_pkg::MEM_MAX;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NB    = vgts_pkg::NBANK;

  logic adv;
  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv && !empty_i;

  logic               wr;
  logic [NB-1:0][31:0] rd_q;
  assign wr = pop_o && !pop_data_i.is_query && pop_data_i.wr_en;

  // every in-grid load goes to all copies; copy k serves neighbor k
  for (genvar k = 0; k < NB; k++) begin : g_copy
    logic [31:0] mem_q [DEPTH];
    always_ff @(posedge clk_i) begin
      if (wr) mem_q[pop_data_i.wr_addr[AW-1:0]] <= pop_data_i.wr_data;
      if (adv) rd_q[k] <= mem_q[pop_data_i.rd_addr[k][AW-1:0]];
    end
  end

  logic [2:0]          v_q;
  logic [2:0]          ins_q;
  logic [15:0]         tx_q;
  logic [1:0][15:0]    ty_q;
  logic [2:0][15:0]    tz_q;
  logic [3:0][31:0]    c4_q;
  logic [1:0][31:0]    c2_q;
  logic                out_v_q;
  logic [31:0]         dens_q;
  logic                ins_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q     <= {v_q[1:0], pop_o && pop_data_i.is_query};
      out_v_q <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ins_q     <= {ins_q[1:0], pop_data_i.in_box};
      tx_q      <= pop_data_i.tx;
      ty_q      <= {ty_q[0], pop_data_i.ty};
      tz_q      <= {tz_q[1:0], pop_data_i.tz};
      for (int j = 0; j < 4; j++) begin
        c4_q[j] <= vgts_pkg::lerp16(rd_q[2*j], rd_q[2*j+1], tx_q);
      end
      c2_q[0]   <= vgts_pkg::lerp16(c4_q[0], c4_q[1], ty_q[1]);
      c2_q[1]   <= vgts_pkg::lerp16(c4_q[2], c4_q[3], ty_q[1]);
      dens_q    <= ins_q[2] ? vgts_pkg::lerp16(c2_q[0], c2_q[1], tz_q[2]) : 32'd0;
      ins_out_q <= ins_q[2];
    end
  end

  assign out_valid_o  = out_v_q;
  assign density_o    = dens_q;
  assign inside_res_o = ins_out_q;

endmodule

FILE: hw/rtl/voxel_grid_trilinear_sample.sv
// Top level of the voxel grid trilinear density sampler.
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one beat per item:
//    operation_i selects a sample load or a density query.
//  - Loads write load_value_i at flat index load_index_i and give no result;
//    indexes beyond the grid are dropped.
//  - Queries return one output beat (out_valid_o / out_stall_i) with
//    density_o and inside_res_o; outside the box both are zero.
//  - Throughput: one beat per cycle, loads and queries mixed, while the
//    output is not stalled. Path from input beat to result: 3 front stages,
//    queue, memory read, 3 blend stages.
//  - The front maps each axis (subtract, 32x32 multiply, clamp) and queues
//    classified beats; the back reads all eight neighbors in the same cycle
//    from eight copies of the grid memory and blends x, then y, then z.
//  - A stalled output holds the back; the 4-entry queue lets the front
//    keep accepting until it fills, then in_stall_o rises.
//  - Reset clears config to origin 0 and scale 32.0 and empties the
//    pipeline; grid memory is not cleared and must be loaded before use.
//  - Config writes (cfg_we_i) are taken at any edge, meant while idle.
`timescale 1ns / 1ps
module voxel_grid_trilinear_sample #(
  parameter int unsigned GRID_X = vgts_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = vgts_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z = vgts_pkg::GRID_Z_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vgts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [vgts_pkg::LOAD_W-1:0]    load_index_i,
  input  logic [31:0]                    load_value_i,
  input  logic signed [31:0]             point_x_i,
  input  logic signed [31:0]             point_y_i,
  input  logic signed [31:0]             point_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    density_o,
  output logic                           inside_res_o
);

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  vgts_pkg::qent_t push_data;
  vgts_pkg::qent_t pop_data;

  vgts_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .operation_i, .load_index_i, .load_value_i,
    .point_x_i, .point_y_i, .point_z_i,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  vgts_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  vgts_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .pop_data_i(pop_data), .pop_o(pop),
    .out_valid_o, .out_stall_i, .density_o, .inside_res_o
  );

endmodule

FILE: verif/voxel_grid_trilinear_sample_tb.sv
// Self-checking testbench for the voxel grid trilinear density sampler.
`timescale 1ns / 1ps
module voxel_grid_trilinear_sample_tb;

  localparam int unsigned NX = vgts_pkg::GRID_X_DEF;
  localparam int unsigned NY = vgts_pkg::GRID_Y_DEF;
  localparam int unsigned NZ = vgts_pkg::GRID_Z_DEF;
  localparam int unsigned CELLS = NX * NY * NZ;
  localparam int unsigned LW = vgts_pkg::LOAD_W;
  localparam int unsigned CIW = vgts_pkg::CFG_IDX_W;
  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 16;  // a margin above the pipeline latency

  logic clk = 1'b0, rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CIW-1:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0, in_stall;
  logic operation = 1'b0;
  logic [LW-1:0] load_index = '0;
  logic [31:0] load_value = '0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic out_valid, out_stall = 1'b0;
  logic [31:0] density;
  logic inside_res;

  voxel_grid_trilinear_sample u_dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .load_index_i(load_index), .load_value_i(load_value),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .density_o(density), .inside_res_o(inside_res)
  );

  typedef struct packed {
    logic [31:0] dens;
    logic        ins;
  } sample_res_t;

  // Scoreboard: own copy of grid and config, predicts one result per query.
  class density_scoreboard;
    logic [31:0] grid[CELLS];
    bit written[CELLS];
    logic [31:0] org[3];
    logic [31:0] scl[3];
    sample_res_t pending[$];
    int errors;

    function new();
      errors = 0;
      foreach (org[a]) begin
        org[a] = '0;
        scl[a] = 32'd2097152;
      end
    endfunction

    function void set_reg(vgts_pkg::cfg_reg_e r, logic [31:0] v);
      case (r)
        vgts_pkg::REG_ORIGIN_X: org[0] = v;
        vgts_pkg::REG_ORIGIN_Y: org[1] = v;
        vgts_pkg::REG_ORIGIN_Z: org[2] = v;
        vgts_pkg::REG_SCALE_X:  scl[0] = v;
        vgts_pkg::REG_SCALE_Y:  scl[1] = v;
        vgts_pkg::REG_SCALE_Z:  scl[2] = v;
        default: ;
      endcase
    endfunction

    // Per-axis mapping to voxel neighbors and fractional weight.
    function bit axis_map(logic [31:0] p, int a, int unsigned n,
                          output int unsigned lo, output int unsigned hi,
                          output logic [15:0] t);
      longint off, v, i;
      logic [63:0] s;
      off = longint'($signed(p)) - longint'($signed(org[a]));
      lo = 0; hi = 0; t = '0;
      if (off < 0) return 0;
      s = 64'(off) * 64'(scl[a]);
      if (s > (64'(n) << 32)) return 0;
      v = longint'(s >> 16) - 32768;
      if (v < 0) begin
        i = -1;
        t = 16'(v + 65536);
      end else begin
        i = v >>> 16;
        t = v[15:0];
      end
      lo = (i < 0) ? 0 : (i > n - 1) ? n - 1 : int'(i);
      hi = (i + 1 > n - 1) ? n - 1 : int'(i + 1);
      return 1;
    endfunction

    // First neighbor of an in-box point that holds no sample yet.
    function bit first_unwritten(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                 output int unsigned idx);
      int unsigned x0, x1, y0, y1, z0, z1;
      logic [15:0] tx, ty, tz;
      idx = 0;
      if (!(axis_map(px, 0, NX, x0, x1, tx) && axis_map(py, 1, NY, y0, y1, ty) &&
            axis_map(pz, 2, NZ, z0, z1, tz)))
        return 0;
      for (int k = 0; k < 8; k++) begin
        idx = ((k[2] ? z1 : z0) * NY + (k[1] ? y1 : y0)) * NX + (k[0] ? x1 : x0);
        if (!written[idx]) return 1;
      end
      return 0;
    endfunction

    function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [15:0] t);
      logic [63:0] acc;
      acc = 64'(a) * (64'd65536 - 64'(t)) + 64'(b) * 64'(t);
      return acc[47:16];
    endfunction

    function logic [31:0] at(int unsigned x, int unsigned y, int unsigned z);
      return grid[(z * NY + y) * NX + x];
    endfunction

    function void note_beat(vgts_pkg::op_e op, logic [LW-1:0] idx, logic [31:0] val,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      int unsigned x0, x1, y0, y1, z0, z1;
      logic [15:0] tx, ty, tz;
      logic [31:0] c00, c10, c01, c11, c0, c1;
      sample_res_t r;
      if (op == vgts_pkg::OP_LOAD) begin
        if (idx < CELLS) begin
          grid[idx] = val;
          written[idx] = 1'b1;
        end
        return;
      end
      r = '0;
      if (axis_map(px, 0, NX, x0, x1, tx) && axis_map(py, 1, NY, y0, y1, ty) &&
          axis_map(pz, 2, NZ, z0, z1, tz)) begin
        c00 = blend(at(x0, y0, z0), at(x1, y0, z0), tx);
        c10 = blend(at(x0, y1, z0), at(x1, y1, z0), tx);
        c01 = blend(at(x0, y0, z1), at(x1, y0, z1), tx);
        c11 = blend(at(x0, y1, z1), at(x1, y1, z1), tx);
        c0 = blend(c00, c10, ty);
        c1 = blend(c01, c11, ty);
        r.dens = blend(c0, c1, tz);
        r.ins = 1'b1;
      end
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] d, logic ins);
      sample_res_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result density=%h inside=%b", d, ins));
        return;
      end
      e = pending.pop_front();
      if (d !== e.dens) report($sformatf("density %h, expected %h", d, e.dens));
      if (ins !== e.ins) report($sformatf("inside_res %b, expected %b", ins, e.ins));
    endtask
  endclass

  density_scoreboard sb = new();

  initial begin
    forever #5 clk = ~clk;
  end

  longint unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: compare every accepted output beat.
  always @(posedge clk)
    if (rst_ni && out_valid && !out_stall) sb.check_result(density, inside_res);

  // Receiver stall pattern; one long hold-off when asked, counted here.
  int hold_req = 0;
  int stall_pct = 30;
  always @(negedge clk) begin
    if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_req <= hold_req - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Sender burst state: beats left in the current burst.
  int burst_left = 0;

  // Offer one beat from the falling edge, hold until accepted.
  task send_beat(vgts_pkg::op_e op, logic [LW-1:0] idx, logic [31:0] val,
                 logic [31:0] px, logic [31:0] py, logic [31:0] pz, bit gaps);
    if (gaps && burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid = 1'b1;
    operation = op;
    load_index = idx;
    load_value = val;
    point_x = px;
    point_y = py;
    point_z = pz;
    do @(posedge clk); while (in_stall);
    sb.note_beat(op, idx, val, px, py, pz);
    @(negedge clk);
  endtask

  function logic [31:0] fill_value();
    return ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
  endfunction

  // Load any neighbor sample the query would read before it is set, then query.
  task send_query(logic [LW-1:0] idx, logic [31:0] val, logic [31:0] px,
                  logic [31:0] py, logic [31:0] pz, bit gaps);
    int unsigned slot;
    bit need;
    need = sb.first_unwritten(px, py, pz, slot);
    while (need) begin
      send_beat(vgts_pkg::OP_LOAD, slot[LW-1:0], fill_value(), '0, '0, '0, gaps);
      need = sb.first_unwritten(px, py, pz, slot);
    end
    send_beat(vgts_pkg::OP_QUERY, idx, val, px, py, pz, gaps);
  endtask

  task go_idle();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_reg(vgts_pkg::cfg_reg_e r, logic [31:0] v);
    cfg_we = 1'b1;
    cfg_idx = r;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(r, v);
  endtask

  task set_box(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
               logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    write_reg(vgts_pkg::REG_ORIGIN_X, ox);
    write_reg(vgts_pkg::REG_ORIGIN_Y, oy);
    write_reg(vgts_pkg::REG_ORIGIN_Z, oz);
    write_reg(vgts_pkg::REG_SCALE_X, sx);
    write_reg(vgts_pkg::REG_SCALE_Y, sy);
    write_reg(vgts_pkg::REG_SCALE_Z, sz);
  endtask

  // Mostly in the first few voxels, sometimes at or past the far face or below origin.
  function logic [31:0] pick_coord(int a);
    logic [63:0] span, near, off;
    int unsigned n;
    n = (a == 0) ? NX : (a == 1) ? NY : NZ;
    if (sb.scl[a] == 0) begin
      span = 64'hFFFF_FFFF;
      near = 64'hFFFF_FFFF;
    end else begin
      span = (64'(n) << 32) / 64'(sb.scl[a]) + 2;
      near = (64'd3 << 32) / 64'(sb.scl[a]);
    end
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    if (near > 64'hFFFF_FFFF) near = 64'hFFFF_FFFF;
    off = {$urandom, $urandom} % (near + 1);
    if ($urandom_range(9) == 0) off = span - $urandom_range(3);
    if ($urandom_range(19) == 0) return sb.org[a] - $urandom_range(1, 4);
    return sb.org[a] + off[31:0];
  endfunction

  task random_items(int count);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1, 2: send_beat(vgts_pkg::OP_LOAD, LW'($urandom), $urandom, $urandom, $urandom,
                           $urandom, 1'b1);
        3:       send_query(LW'($urandom), $urandom, $urandom, $urandom, $urandom, 1'b1);
        default: send_query(LW'($urandom), $urandom, pick_coord(0), pick_coord(1),
                            pick_coord(2), 1'b1);
      endcase
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Directed at reset config: scale 32.0, box spans [0, 1.0] on each axis.
    send_query('0, '0, 32'h0, 32'h0, 32'h0, 1'b1);                // corner
    send_query('0, '0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b1);  // far face
    send_query('0, '0, 32'h1_0001, 32'h8000, 32'h8000, 1'b1);     // just past
    send_query('0, '0, 32'h8000, 32'hFFFF_FFFF, 32'h8000, 1'b1);  // below origin
    send_query('0, '0, 32'h8000, 32'h8000, 32'h7FFF_FFFF, 1'b1);
    send_query('0, '0, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
    send_query('0, '0, 32'h0400, 32'h0C00, 32'hFC00, 1'b1);       // voxel centers
    send_beat(vgts_pkg::OP_LOAD, 15'h7FFF, 32'hFFFF_FFFF, '0, '0, '0, 1'b1);
    send_beat(vgts_pkg::OP_LOAD, 15'h0000, 32'h0, '0, '0, '0, 1'b1);
    send_query('0, '0, 32'hFFFF, 32'hFFFF, 32'hFFFF, 1'b1);
    send_query('0, '0, 32'h0001, 32'h0001, 32'h0001, 1'b1);
    random_items(80);
    go_idle();  // sender waits for every result

    // Arbitrary box.
    set_box($urandom, $urandom, $urandom, $urandom_range(32'h40_0000, 32'h1_0000),
            $urandom_range(32'h40_0000, 32'h1_0000), $urandom);
    // Receiver holds off while the sender keeps offering beats.
    stall_pct = 20;
    hold_req = 120;
    random_items(100);
    go_idle();

    // Extremes: lowest origin, largest scale.
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF);
    send_query('0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_query('0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
    stall_pct = 0;
    random_items(70);
    go_idle();

    // Zero scale with the highest origin: everything at the origin maps to voxel 0.
    set_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0);
    send_query('0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_query('0, '0, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    stall_pct = 60;
    random_items(70);
    go_idle();

    // Zero scale on x and z at low origins, random y axis, then one more random box.
    set_box(32'h8000_0000, $urandom, 32'h0, '0, $urandom_range(32'h80_0000), '0);
    stall_pct = 30;
    random_items(70);
    go_idle();
    set_box($urandom, $urandom, $urandom, $urandom_range(32'h100_0000),
            $urandom_range(32'h100_0000), $urandom_range(32'h100_0000));
    random_items(80);
    go_idle();

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: voxel_grid_trilinear_sample.f
hw/rtl/vgts_pkg.sv
hw/rtl/vgts_front.sv
hw/rtl/vgts_queue.sv
hw/rtl/vgts_back.sv
hw/rtl/voxel_grid_trilinear_sample.sv
verif/voxel_grid_trilinear_sample_tb.sv
